>>> rtl/fncl_pkg.sv
// Shared constants, codes and types for the FAT next-cluster lookup block.
package fncl_pkg;

    // Window geometry; SECTOR_BYTES is a power of two
    localparam int CACHE_SECTORS = 4;
    localparam int SECTOR_BYTES  = 512;
    localparam int WINDOW_BYTES  = CACHE_SECTORS * SECTOR_BYTES;
    localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
    localparam int WIN_AW        = $clog2(WINDOW_BYTES);
    localparam int REL_W         = WIN_AW + 1;

    // Field widths
    localparam int CLUSTER_W = 28;
    localparam int OFF_W     = CLUSTER_W + 2;
    localparam int FOFF_W    = 11;
    localparam int BYTE_W    = 8;
    localparam int NEXT_W    = 32;
    localparam int LBA_W     = 22;
    localparam int RSV_W     = 16;
    localparam int FTYPE_W   = 2;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 56;

    // Entry format codes
    localparam logic [FTYPE_W-1:0] FAT_TYPE_12 = 2'd0;
    localparam logic [FTYPE_W-1:0] FAT_TYPE_16 = 2'd1;
    localparam logic [FTYPE_W-1:0] FAT_TYPE_32 = 2'd2;

    // Configuration register indexes
    localparam logic REG_FAT_TYPE = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    // Input kinds
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    // End-of-chain detection and extension
    localparam logic [11:0]       FAT12_MASK    = 12'hFFF;
    localparam logic [11:0]       FAT12_EOC_MIN = 12'hFF8;
    localparam logic [NEXT_W-1:0] FAT12_EXT     = 32'hFFFFF000;
    localparam logic [15:0]       FAT16_EOC_MIN = 16'hFFF8;
    localparam logic [NEXT_W-1:0] FAT16_EXT     = 32'hFFFF0000;

    // One result beat before packing
    typedef struct packed {
        logic              hit;
        logic [NEXT_W-1:0] next_cluster;
        logic              fetch_request;
        logic [LBA_W-1:0]  fetch_lba;
    } res_t;

endpackage

>>> rtl/fncl_ram.sv
// Generic single-port RAM with registered read data.
module fncl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fat_next_cluster_lookup.sv
// FAT next-cluster lookup top level: sequencer, shared adder and window memory.
//
// Each input beat is either a lookup (tuser 0) or a window fill (tuser 1), and
// each gives exactly one result beat. A fill writes one byte of the 2048-byte
// window. A lookup runs a small sequencer around one shared 32-bit adder:
// entry offset, window range check, end-of-window check, then one window byte
// read per cycle from the single memory port. A miss moves the window base to
// the entry's sector and returns fetch_request with the absolute LBA. The input
// side takes one beat at a time; a finished result waits in the output register
// while the next beat is accepted. The window memory is not cleared: a lookup
// that hits bytes never filled returns undefined data.
module fat_next_cluster_lookup
    import fncl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [RSV_W-1:0]     cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // cluster[27:0], fill_offset[38:28], fill_byte[46:39]
    input  logic                 s_tuser,   // action[0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // next_cluster[31:0], fetch_lba[53:32]
    output logic [1:0]           m_tuser    // hit[0], fetch_request[1]
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_CALC = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_END  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_RDW  = 4'd6;
    localparam logic [3:0] S_DEC  = 4'd7;
    localparam logic [3:0] S_MISS = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [FTYPE_W-1:0]   fat_type_reg;
    logic [RSV_W-1:0]     reserved_reg;
    logic [LBA_W-1:0]     base_reg;
    logic                 valid_reg;

    logic                 action_reg;
    logic [CLUSTER_W-1:0] cluster_reg;
    logic [FOFF_W-1:0]    fill_off_reg;
    logic [BYTE_W-1:0]    fill_byte_reg;

    logic [OFF_W-1:0]     off_reg;
    logic [REL_W-1:0]     rel_reg;
    logic [1:0]           idx_reg;
    logic                 pend_reg;
    logic [1:0]           pidx_reg;
    logic [NEXT_W-1:0]    word_reg;
    res_t                 res_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    logic                 s_accept;
    logic                 is12, is16, is32;
    logic [1:0]           last_idx;
    logic [31:0]          sector32;
    logic                 out_free;

    // shared adder
    logic [31:0]          alu_a, alu_b;
    logic                 alu_sub;
    logic [32:0]          alu_res;

    logic                 in_win;
    logic [31:0]          rel32;
    logic [29:0]          off_calc;

    logic                 ram_we;
    logic [WIN_AW-1:0]    ram_addr;
    logic [BYTE_W-1:0]    ram_rdata;

    logic [15:0]          w16;
    logic [11:0]          v12;
    logic [NEXT_W-1:0]    dec_val;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign is12     = (fat_type_reg == FAT_TYPE_12);
    assign is16     = (fat_type_reg == FAT_TYPE_16);
    assign is32     = !is12 && !is16;
    assign last_idx = is32 ? 2'd3 : 2'd1;
    assign sector32 = 32'(off_reg >> SECTOR_SHIFT);

    // Steer the shared adder by sequencer step
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_CALC:
            begin
                // FAT12: c + 2c, FAT16: c + c, FAT32: 2c + 2c
                alu_a = is16 || is12 ? 32'(cluster_reg) : 32'({cluster_reg, 1'b0});
                alu_b = is16 ? 32'(cluster_reg) : 32'({cluster_reg, 1'b0});
            end
            S_CHK:
            begin
                alu_a   = sector32;
                alu_b   = 32'(base_reg);
                alu_sub = 1'b1;
            end
            S_END:
            begin
                // entry end: relative offset plus entry length
                alu_a = 32'(rel_reg);
                alu_b = 32'(last_idx) + 32'd1;
            end
            S_RD:
            begin
                alu_a = 32'(rel_reg);
                alu_b = 32'(idx_reg);
            end
            S_MISS:
            begin
                alu_a = 32'(reserved_reg);
                alu_b = sector32;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);
    assign off_calc = is12 ? alu_res[30:1] : alu_res[29:0];

    // Window hit: no borrow on sector - base and difference below the sector count
    assign in_win = valid_reg && alu_res[32] && (alu_res[31:0] < 32'(CACHE_SECTORS));
    assign rel32  = (alu_res[31:0] << SECTOR_SHIFT) | 32'(off_reg[SECTOR_SHIFT-1:0]);

    // Window memory port: fill writes, lookup reads
    assign ram_we   = (state_reg == S_FILL) && (32'(fill_off_reg) < 32'(WINDOW_BYTES));
    assign ram_addr = (state_reg == S_FILL) ? WIN_AW'(fill_off_reg) : alu_res[WIN_AW-1:0];

    fncl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (fill_byte_reg),
        .rdata (ram_rdata)
    );

    // Decode the gathered entry
    assign w16 = word_reg[15:0];
    assign v12 = cluster_reg[0] ? w16[15:4] : (w16[11:0] & FAT12_MASK);
    always_comb
    begin
        if (is12)
        begin
            dec_val = (v12 >= FAT12_EOC_MIN) ? (32'(v12) | FAT12_EXT) : 32'(v12);
        end
        else if (is16)
        begin
            dec_val = (w16 >= FAT16_EOC_MIN) ? (32'(w16) | FAT16_EXT) : 32'(w16);
        end
        else
        begin
            dec_val = word_reg;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_tuser == ACT_FILL) ? S_FILL : S_CALC;
                end
            end
            S_FILL:  state_next = S_FIN;
            S_CALC:  state_next = S_CHK;
            S_CHK:   state_next = in_win ? S_END : S_MISS;
            S_END:   state_next = (alu_res <= 33'(WINDOW_BYTES)) ? S_RD : S_MISS;
            S_RD:    state_next = (idx_reg == last_idx) ? S_RDW : S_RD;
            S_RDW:   state_next = S_DEC;
            S_DEC:   state_next = S_FIN;
            S_MISS:  state_next = S_FIN;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fat_type_reg <= FAT_TYPE_12;
            reserved_reg <= '0;
            base_reg     <= '0;
            valid_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_RD);

            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FAT_TYPE: fat_type_reg <= cfg_data[FTYPE_W-1:0];
                    REG_RESERVED: reserved_reg <= cfg_data;
                    default:      reserved_reg <= reserved_reg;
                endcase
            end

            // Move the window on a miss
            if (state_reg == S_MISS)
            begin
                base_reg  <= sector32[LBA_W-1:0];
                valid_reg <= 1'b1;
            end

            // Hand off result beat
            if (state_reg == S_FIN && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            action_reg    <= s_tuser;
            cluster_reg   <= s_tdata[CLUSTER_W-1:0];
            fill_off_reg  <= s_tdata[CLUSTER_W+FOFF_W-1:CLUSTER_W];
            fill_byte_reg <= s_tdata[CLUSTER_W+FOFF_W+BYTE_W-1:CLUSTER_W+FOFF_W];
        end

        case (state_reg)
            S_FILL:
            begin
                res_reg <= '0;
            end
            S_CALC:
            begin
                off_reg <= off_calc;
            end
            S_CHK:
            begin
                rel_reg <= rel32[REL_W-1:0];
            end
            S_END:
            begin
                idx_reg  <= '0;
                word_reg <= '0;
            end
            S_RD:
            begin
                idx_reg  <= idx_reg + 2'd1;
                pidx_reg <= idx_reg;
            end
            S_DEC:
            begin
                res_reg.hit           <= 1'b1;
                res_reg.next_cluster  <= dec_val;
                res_reg.fetch_request <= 1'b0;
                res_reg.fetch_lba     <= '0;
            end
            S_MISS:
            begin
                res_reg.hit           <= 1'b0;
                res_reg.next_cluster  <= '0;
                res_reg.fetch_request <= 1'b1;
                res_reg.fetch_lba     <= alu_res[LBA_W-1:0];
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase

        // Gather read bytes little-endian
        if (pend_reg)
        begin
            word_reg[{pidx_reg, 3'b000} +: BYTE_W] <= ram_rdata;
        end

        // Load output register
        if (state_reg == S_FIN && out_free)
        begin
            m_tdata_reg <= {2'b00, res_reg.fetch_lba, res_reg.next_cluster};
            m_tuser_reg <= {res_reg.fetch_request, res_reg.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A result beat is never both a hit and a fetch request
    a_hit_xor_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flags hit and fetch_request both set");

    // A fill never produces a hit or a fetch request
    a_fill_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && (action_reg == ACT_FILL)
        |-> !res_reg.hit && !res_reg.fetch_request)
        else $error("fill item produced a lookup result");

    // A miss always leaves a valid window behind
    a_miss_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> valid_reg)
        else $error("miss reported with no window marked valid");

    // Read data is only gathered right after a read step
    a_pend_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == S_RD))
        else $error("window read data captured outside a read step");

endmodule

>>> dv/fat_next_cluster_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for the FAT next-cluster lookup: chain walks, window fills, misses and stalls.
module fat_next_cluster_lookup_tb;
    import fncl_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_BEATS = 1020;
    localparam int PHASES       = 8;
    localparam int MAX_IDLE     = 17;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;

    // Type code 3 has no name in the package; it decodes like FAT32
    localparam logic [FTYPE_W-1:0] FAT_TYPE_ALT   = 2'd3;
    localparam logic [27:0]        FAT32_EOC_MIN  = 28'hFFFFFF8;
    localparam int unsigned        FAT12_MAX_CLUS = 32'h00000FFF;
    localparam int unsigned        FAT16_MAX_CLUS = 32'h0000FFFF;
    localparam int unsigned        FAT32_MAX_CLUS = 32'h0FFFFFFF;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [RSV_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // cluster[27:0], fill_offset[38:28], fill_byte[46:39]
    logic                s_tuser;   // action[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // next_cluster[31:0], fetch_lba[53:32]
    logic [1:0]          m_tuser;   // hit[0], fetch_request[1]

    // Predicted block state
    logic [BYTE_W-1:0]  fat_mem [WINDOW_BYTES];
    bit                 fat_mem_ok [WINDOW_BYTES];
    logic [LBA_W-1:0]   mdl_base = '0;
    bit                 mdl_valid = 1'b0;
    logic [FTYPE_W-1:0] mdl_type = FAT_TYPE_12;
    logic [RSV_W-1:0]   mdl_rsv = '0;

    res_t pending_links [$];
    res_t head_link;

    int fail_count = 0;
    int n_beats = 0;
    int n_hits = 0;
    int n_misses = 0;
    int n_fills = 0;
    int n_cfg_writes = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    int hold_req = 0;
    bit hold_active = 1'b0;

    fat_next_cluster_lookup u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Largest cluster number the current entry format can hold
    function automatic int unsigned clus_limit();
        case (mdl_type)
            FAT_TYPE_12: return FAT12_MAX_CLUS;
            FAT_TYPE_16: return FAT16_MAX_CLUS;
            default:     return FAT32_MAX_CLUS;
        endcase
    endfunction

    // Find the entry of a cluster; returns 1 when it lies wholly in the window
    function automatic bit locate_entry(input logic [CLUSTER_W-1:0] c,
                                        output longint unsigned sector,
                                        output int rel, output int len);
        longint unsigned off;
        longint unsigned start;
        case (mdl_type)
            FAT_TYPE_12:
            begin
                off = (64'(c) * 3) / 2;
                len = 2;
            end
            FAT_TYPE_16:
            begin
                off = 64'(c) * 2;
                len = 2;
            end
            default:
            begin
                off = 64'(c) * 4;
                len = 4;
            end
        endcase
        sector = off / SECTOR_BYTES;
        start = 64'(mdl_base) * SECTOR_BYTES;
        rel = 0;
        if (mdl_valid && sector >= 64'(mdl_base) && sector < 64'(mdl_base) + CACHE_SECTORS)
        begin
            rel = int'(off - start);
            return (rel + len <= WINDOW_BYTES);
        end
        return 1'b0;
    endfunction

    // Apply one accepted beat to the predicted state and return its result
    function automatic res_t predict_beat(input logic act, input logic [CLUSTER_W-1:0] c,
                                          input logic [FOFF_W-1:0] fo,
                                          input logic [BYTE_W-1:0] fb);
        res_t res;
        longint unsigned sector;
        int rel;
        int len;
        logic [15:0] word;
        logic [11:0] short_val;
        res = '0;
        if (act == ACT_FILL)
        begin
            if (fo < WINDOW_BYTES)
            begin
                fat_mem[fo] = fb;
                fat_mem_ok[fo] = 1'b1;
            end
            return res;
        end
        if (locate_entry(c, sector, rel, len))
        begin
            res.hit = 1'b1;
            word = {fat_mem[rel + 1], fat_mem[rel]};
            case (mdl_type)
                FAT_TYPE_12:
                begin
                    // odd clusters sit in the upper 12 bits of the word
                    short_val = c[0] ? word[15:4] : (word[11:0] & FAT12_MASK);
                    res.next_cluster = NEXT_W'(short_val);
                    if (short_val >= FAT12_EOC_MIN)
                        res.next_cluster |= FAT12_EXT;
                end
                FAT_TYPE_16:
                begin
                    res.next_cluster = NEXT_W'(word);
                    if (word >= FAT16_EOC_MIN)
                        res.next_cluster |= FAT16_EXT;
                end
                default:
                    res.next_cluster = {fat_mem[rel + 3], fat_mem[rel + 2], word};
            endcase
        end
        else
        begin
            // move the window; its bytes count as stale until refilled
            mdl_base = LBA_W'(sector);
            mdl_valid = 1'b1;
            foreach (fat_mem_ok[i])
                fat_mem_ok[i] = 1'b0;
            res.fetch_request = 1'b1;
            res.fetch_lba = LBA_W'(64'(mdl_rsv) + sector);
        end
        return res;
    endfunction

    // Cluster whose entry falls in (or right at) the current window, else any cluster within the format's limit
    function automatic logic [CLUSTER_W-1:0] near_cluster();
        longint unsigned off;
        longint unsigned c;
        off = 64'(mdl_base) * SECTOR_BYTES + $urandom_range(0, WINDOW_BYTES - 1);
        case (mdl_type)
            FAT_TYPE_12: c = (off * 2) / 3;
            FAT_TYPE_16: c = off / 2;
            default:     c = off / 4;
        endcase
        if (c > clus_limit())
            c = $urandom_range(0, clus_limit());
        return CLUSTER_W'(c);
    endfunction

    // Choose the entry value that links a cluster to the next one
    function automatic logic [NEXT_W-1:0] pick_link(input logic [CLUSTER_W-1:0] cur);
        logic [NEXT_W-1:0] eoc_lo;
        logic [NEXT_W-1:0] v;
        int r;
        case (mdl_type)
            FAT_TYPE_12: eoc_lo = NEXT_W'(FAT12_EOC_MIN);
            FAT_TYPE_16: eoc_lo = NEXT_W'(FAT16_EOC_MIN);
            default:     eoc_lo = NEXT_W'(FAT32_EOC_MIN);
        endcase
        r = $urandom_range(0, 9);
        if (r < 4)
            v = (NEXT_W'(cur) + 1 > clus_limit()) ? NEXT_W'(2) : NEXT_W'(cur) + 1;
        else if (r < 6)
            v = NEXT_W'(near_cluster());
        else if (r == 6)
            v = eoc_lo + $urandom_range(0, 7);
        else if (r == 7)
            v = $urandom_range(0, clus_limit());
        else if (r == 8)
            v = $urandom_range(0, 1) ? eoc_lo - 1 : NEXT_W'($urandom_range(0, 1));
        else
            v = $urandom;
        if (mdl_type == FAT_TYPE_12 || mdl_type == FAT_TYPE_16)
            v = v & clus_limit();
        else
            v[31:28] = 4'($urandom);
        return v;
    endfunction

    function automatic bit chain_ends(input logic [NEXT_W-1:0] v);
        case (mdl_type)
            FAT_TYPE_12: return v[11:0] >= FAT12_EOC_MIN;
            FAT_TYPE_16: return v[15:0] >= FAT16_EOC_MIN;
            default:     return v[27:0] >= FAT32_EOC_MIN;
        endcase
    endfunction

    // Offer one beat after a random gap; predict it once accepted
    task automatic send_beat(input logic act, input logic [CLUSTER_W-1:0] c,
                             input logic [FOFF_W-1:0] fo, input logic [BYTE_W-1:0] fb);
        int gap;
        res_t res;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {1'b0, fb, fo, c};
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_beat(act, c, fo, fb);
        pending_links.push_back(res);
        n_beats++;
        if (act == ACT_FILL)
            n_fills++;
        else if (res.hit)
            n_hits++;
        else
            n_misses++;
    endtask

    task automatic send_fill(input int pos, input logic [BYTE_W-1:0] b);
        send_beat(ACT_FILL, CLUSTER_W'($urandom), FOFF_W'(pos), b);
    endtask

    // Look up a cluster, first filling any stale bytes of an entry that would hit
    task automatic lookup_safe(input logic [CLUSTER_W-1:0] c);
        longint unsigned sector;
        int rel;
        int len;
        if (locate_entry(c, sector, rel, len))
        begin
            for (int i = 0; i < len; i++)
            begin
                if (!fat_mem_ok[rel + i])
                    send_fill(rel + i, BYTE_W'($urandom));
            end
        end
        send_beat(ACT_LOOKUP, c, FOFF_W'($urandom), BYTE_W'($urandom));
    endtask

    // Miss if needed, write the entry bytes, then look it up again as a hit
    task automatic plant_entry(input logic [CLUSTER_W-1:0] c, input logic [NEXT_W-1:0] val);
        longint unsigned sector;
        int rel;
        int len;
        logic [15:0] word;
        logic [NEXT_W-1:0] raw;
        if (!locate_entry(c, sector, rel, len))
            lookup_safe(c);
        void'(locate_entry(c, sector, rel, len));
        if (mdl_type == FAT_TYPE_12)
        begin
            // keep the neighbor's nibble where it is already known
            word = {fat_mem_ok[rel + 1] ? fat_mem[rel + 1] : BYTE_W'($urandom),
                    fat_mem_ok[rel] ? fat_mem[rel] : BYTE_W'($urandom)};
            if (c[0])
                word[15:4] = val[11:0];
            else
                word[11:0] = val[11:0];
            raw = NEXT_W'(word);
        end
        else
            raw = val;
        for (int i = 0; i < len; i++)
            send_fill(rel + i, raw[8 * i +: 8]);
        lookup_safe(c);
    endtask

    // Follow a chain, planting each link before looking it up
    task automatic walk_chain(input logic [CLUSTER_W-1:0] start, input int steps);
        logic [CLUSTER_W-1:0] cur;
        logic [NEXT_W-1:0] link;
        cur = start;
        for (int i = 0; i < steps; i++)
        begin
            link = pick_link(cur);
            plant_entry(cur, link);
            if ($urandom_range(0, 3) == 0)
                lookup_safe(cur);
            if (chain_ends(link))
                break;
            cur = link[CLUSTER_W-1:0];
        end
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_links.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [RSV_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FAT_TYPE)
            mdl_type = val[FTYPE_W-1:0];
        else
            mdl_rsv = val;
        n_cfg_writes++;
    endtask

    // Reconfigure only with the block idle and every result returned
    task automatic set_config(input logic [FTYPE_W-1:0] ftype, input logic [RSV_W-1:0] rsv);
        idle_input();
        wait_drained();
        write_reg(REG_FAT_TYPE, RSV_W'(ftype));
        write_reg(REG_RESERVED, rsv);
    endtask

    // After reset: FAT12, no reserved sectors, no window cached
    task automatic test_reset_defaults();
        lookup_safe('0);
    endtask

    // Even and odd entries, end marks, and an entry crossing the window end
    task automatic test_fat12_entries();
        set_config(FAT_TYPE_12, 16'd1);
        plant_entry(28'd2, 32'hFFF);
        plant_entry(28'd3, 32'hFF8);
        plant_entry(28'd1365, 32'h123);
    endtask

    task automatic test_fat16_entries();
        set_config(FAT_TYPE_16, 16'hFFFF);
        plant_entry(28'hFFFF, 32'hFFF8);
        plant_entry(28'hFFFE, 32'hFFF7);
    endtask

    // Largest LBA, raw 32-bit entries, and type code 3
    task automatic test_fat32_entries();
        set_config(FAT_TYPE_32, 16'hFFFF);
        plant_entry(28'hFFFFFFF, 32'hFFFFFFFF);
        set_config(FAT_TYPE_ALT, 16'h0);
        plant_entry(28'h0, 32'h80000001);
    endtask

    // Hold the result side off while the sender keeps offering beats
    task automatic test_output_stall();
        set_config(FAT_TYPE_16, 16'h0100);
        hold_req = HOLD_CYCLES;
        wait (hold_active);
        no_idle = 1'b1;
        repeat (16) lookup_safe(near_cluster());
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase_end;
        int r;
        logic [FTYPE_W-1:0] ftype;
        logic [RSV_W-1:0] rsv;
        for (int p = 0; p < PHASES; p++)
        begin
            ftype = (p < 4) ? FTYPE_W'(p) : FTYPE_W'($urandom_range(0, 3));
            rsv = (p % 3 == 0) ? RSV_W'(0) : (p % 3 == 1) ? RSV_W'(16'hFFFF) : RSV_W'($urandom);
            set_config(ftype, rsv);
            phase_end = n_beats + RANDOM_BEATS / PHASES;
            while (n_beats < phase_end)
            begin
                no_idle = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 19);
                if (r < 12)
                begin
                    walk_chain($urandom_range(0, 1) ? near_cluster()
                                                    : CLUSTER_W'($urandom_range(0, clus_limit())),
                               $urandom_range(1, 8));
                end
                else if (r < 15)
                begin
                    // noise: stray fills and lookups anywhere in the cluster range
                    repeat ($urandom_range(1, 6))
                    begin
                        if ($urandom_range(0, 1))
                            send_fill($urandom_range(0, WINDOW_BYTES - 1), BYTE_W'($urandom));
                        else
                            lookup_safe(CLUSTER_W'($urandom));
                    end
                end
                else if (r < 17)
                begin
                    // abandoned refill: miss, partial fill, then jump elsewhere
                    lookup_safe(CLUSTER_W'($urandom_range(0, clus_limit())));
                    repeat ($urandom_range(1, 3))
                        send_fill($urandom_range(0, WINDOW_BYTES - 1), BYTE_W'($urandom));
                    lookup_safe(CLUSTER_W'($urandom_range(0, clus_limit())));
                end
                else if (r < 19)
                begin
                    repeat ($urandom_range(4, 16))
                        send_fill($urandom_range(0, WINDOW_BYTES - 1), BYTE_W'($urandom));
                end
                else
                begin
                    // pause the sender until every result is back
                    idle_input();
                    wait_drained();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    function automatic void check_field(input string field, input logic [NEXT_W-1:0] want_v,
                                        input logic [NEXT_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_links.size() == 0)
            begin
                $error("result beat with no prediction pending");
                fail_count++;
            end
            else
            begin
                head_link = pending_links.pop_front();
                check_field("hit", NEXT_W'(head_link.hit), NEXT_W'(m_tuser[0]));
                check_field("next_cluster", head_link.next_cluster, m_tdata[31:0]);
                check_field("fetch_request", NEXT_W'(head_link.fetch_request),
                            NEXT_W'(m_tuser[1]));
                check_field("fetch_lba", NEXT_W'(head_link.fetch_lba), NEXT_W'(m_tdata[53:32]));
            end
        end
    end

    // Result side: random stall per beat, plus a long hold on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            if (hold_req > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                hold_active = 1'b1;
                repeat (hold_req) @(negedge clk);
                hold_req = 0;
                hold_active = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready) && hold_req == 0);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_links.size());
        $display("fat_next_cluster_lookup verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FAT_TYPE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = ACT_LOOKUP;
        s_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_fat12_entries();
        test_fat16_entries();
        test_fat32_entries();
        test_output_stall();
        test_random_traffic();

        // Drain, then watch for stray results
        idle_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d hits, %0d misses, %0d fills", n_beats, n_hits,
                 n_misses, n_fills);
        $display("across %0d register writes, all entry formats and reserved-sector extremes",
                 n_cfg_writes);
        if (fail_count == 0)
            $display("fat_next_cluster_lookup verification clean");
        else
            $display("fat_next_cluster_lookup verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/fncl_pkg.sv
rtl/fncl_ram.sv
rtl/fat_next_cluster_lookup.sv
dv/fat_next_cluster_lookup_tb.sv
